[rtl/awl_pkg.sv]
`default_nettype none

package awl_pkg;

    localparam int TIME_W     = 48;
    localparam int AIR_W      = 16;
    localparam int SUM_W      = 32;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 48'd3600000;

    // register index comes from paddr bit 3 (one 64-bit register per 8 bytes)
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        RD_OLDEST,
        RD_OLDEST_INC,
        RD_PTR_INC
    } rd_sel_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        logic    take_item;
        logic    cap_tmp;
        logic    mrg_write;
        logic    append;
        logic    evict;
        logic    clr_result;
        logic    peek;
        logic    sum_first;
        logic    sum_acc;
        logic    out_load;
    } awl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic count_full;
        logic win_zero;
        logic evict_hit;
        logic rem_one;
        logic out_free;
    } awl_sts_t;

endpackage

`default_nettype wire

[rtl/airtime_window_ledger.sv]
`default_nettype none

// channel   dir  tdata fields (low bit up)              tuser
// s_        in   time_value[47:0] air_time[63:48]        opcode
// m_        out  used_airtime[31:0] oldest_end[79:32]    -
// apb       in   window_length at 0x0 (64-bit word)      -
//
// record: ST_APPEND, preceded by ST_MRG_A, ST_MRG_B and ST_MRG_W when the ring is full
// and the two oldest records merge; query: ST_EV_RD, ST_EV_CHK per evicted record,
// ST_SUM per further summed record, then ST_OUT; a zero window peeks without summing
// the single read port of the record memories sets the walk to one record a cycle
// reset clears ring pointers and loads the window register with WINDOW_RESET; no clearing pass
// a waiting result holds only the output register; new requests are taken meanwhile
// until the next query result is ready and stalls behind it

module airtime_window_ledger #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic      [awl_pkg::IN_DATA_W-1:0]  s_tdata,  // time_value, air_time
    input  wire logic                                s_tuser,  // opcode
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic           [awl_pkg::OUT_DATA_W-1:0] m_tdata,  // used_airtime, oldest_end
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic      [awl_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic      [awl_pkg::APB_DATA_W-1:0] pwdata,
    output logic           [awl_pkg::APB_DATA_W-1:0] prdata,
    output logic                                     pready
);

    import awl_pkg::*;

    awl_cmd_t          cmd;
    awl_sts_t          sts;
    logic              cfg_wr;
    logic [TIME_W-1:0] window_length;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[3] == REG_WINDOW_LENGTH);
    assign prdata = (paddr[3] == REG_WINDOW_LENGTH) ?
                    {{(APB_DATA_W-TIME_W){1'b0}}, window_length} : '0;

    awl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_query (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    awl_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr        (cfg_wr),
        .cfg_data      (pwdata[TIME_W-1:0]),
        .window_length (window_length),
        .in_data       (s_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one still in progress");

    a_no_append_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.append |-> !sts.count_full)
        else $error("append into a full ring");

    a_ring_update_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.mrg_write, cmd.append, cmd.evict, cmd.sum_acc}))
        else $error("conflicting ring updates");

    a_load_into_free_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending one");

endmodule

`default_nettype wire

[rtl/awl_ram.sv]
`default_nettype none

module awl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/awl_ctrl.sv]
`default_nettype none

module awl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic              in_query,
    output logic                   in_ready,
    output awl_pkg::awl_cmd_t      cmd,
    input  wire awl_pkg::awl_sts_t sts
);

    import awl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MRG_A,
        ST_MRG_B,
        ST_MRG_W,
        ST_APPEND,
        ST_EV_RD,
        ST_EV_CHK,
        ST_SUM,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = RD_OLDEST;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.take_item = 1'b1;
                    if (in_query) begin
                        state_next = ST_EV_RD;
                    end else if (sts.count_full) begin
                        state_next = ST_MRG_A;
                    end else begin
                        state_next = ST_APPEND;
                    end
                end
            end
            ST_MRG_A: begin
                cmd.rd_sel = RD_OLDEST;
                state_next = ST_MRG_B;
            end
            ST_MRG_B: begin
                cmd.rd_sel  = RD_OLDEST_INC;
                cmd.cap_tmp = 1'b1;
                state_next  = ST_MRG_W;
            end
            ST_MRG_W: begin
                cmd.mrg_write = 1'b1;
                state_next    = ST_APPEND;
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EV_RD: begin
                cmd.rd_sel = RD_OLDEST;
                if (sts.count_zero) begin
                    cmd.clr_result = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    state_next = ST_EV_CHK;
                end
            end
            ST_EV_CHK: begin
                // next oldest is read ahead so an eviction needs no separate read state
                cmd.rd_sel = RD_OLDEST_INC;
                if (sts.evict_hit) begin
                    cmd.evict = 1'b1;
                    if (sts.count_one) begin
                        cmd.clr_result = 1'b1;
                        state_next     = ST_OUT;
                    end
                end else if (sts.win_zero) begin
                    cmd.peek   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.sum_first = 1'b1;
                    state_next    = sts.count_one ? ST_OUT : ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.rd_sel  = RD_PTR_INC;
                cmd.sum_acc = 1'b1;
                if (sts.rem_one) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/awl_dp.sv]
`default_nettype none

module awl_dp #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr,
    input  wire logic      [awl_pkg::TIME_W-1:0]    cfg_data,
    output logic           [awl_pkg::TIME_W-1:0]    window_length,
    input  wire logic      [awl_pkg::IN_DATA_W-1:0] in_data,
    input  wire awl_pkg::awl_cmd_t                  cmd,
    output awl_pkg::awl_sts_t                       sts,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic           [awl_pkg::OUT_DATA_W-1:0] m_tdata
);

    import awl_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    logic [TIME_W-1:0] window_reg;
    logic [TIME_W-1:0] time_reg;
    logic [AIR_W-1:0]  air_reg;
    logic [TIME_W-1:0] cutoff_reg;
    logic [IW-1:0]     oldest_reg;
    logic [CW-1:0]     count_reg;
    logic [IW-1:0]     ptr_reg;
    logic [CW-1:0]     rem_reg;
    logic [TIME_W-1:0] tmp_end_reg;
    logic [SUM_W-1:0]  tmp_air_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [TIME_W-1:0] oe_reg;
    logic              m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [TIME_W-1:0] in_time;
    logic [AIR_W-1:0]  in_air;
    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] cutoff_next;
    logic [IW-1:0]     oldest_inc;
    logic [IW-1:0]     ptr_inc;
    logic [IW:0]       app_sum;
    logic [IW:0]       app_wrap;
    logic [IW-1:0]     app_addr;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    logic              wr_en;
    logic [TIME_W-1:0] wr_end;
    logic [SUM_W-1:0]  wr_air;
    logic [TIME_W-1:0] rd_end;
    logic [SUM_W-1:0]  rd_air;

    assign in_time     = in_data[TIME_W-1:0];
    assign in_air      = in_data[TIME_W +: AIR_W];
    assign diff        = {1'b0, in_time} - {1'b0, window_reg};
    assign cutoff_next = diff[TIME_W] ? '0 : diff[TIME_W-1:0];

    assign oldest_inc = (oldest_reg == IW'(RING_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    assign ptr_inc    = (ptr_reg == IW'(RING_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign app_sum    = {1'b0, oldest_reg} + (IW+1)'(count_reg);
    assign app_wrap   = (app_sum >= (IW+1)'(RING_DEPTH)) ?
                        app_sum - (IW+1)'(RING_DEPTH) : app_sum;
    assign app_addr   = app_wrap[IW-1:0];

    always_comb begin
        case (cmd.rd_sel)
            RD_OLDEST:     rd_addr = oldest_reg;
            RD_OLDEST_INC: rd_addr = oldest_inc;
            RD_PTR_INC:    rd_addr = ptr_inc;
            default:       rd_addr = oldest_reg;
        endcase
    end

    assign wr_en   = cmd.append | cmd.mrg_write;
    assign wr_addr = cmd.append ? app_addr : oldest_inc;
    assign wr_end  = cmd.append ? time_reg :
                     ((rd_end > tmp_end_reg) ? rd_end : tmp_end_reg);
    assign wr_air  = cmd.append ? {{(SUM_W-AIR_W){1'b0}}, air_reg} :
                     sat_add(tmp_air_reg, rd_air);

    awl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RING_DEPTH)
    ) u_end_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_end),
        .rd_addr (rd_addr),
        .rd_data (rd_end)
    );

    awl_ram #(
        .WIDTH (SUM_W),
        .DEPTH (RING_DEPTH)
    ) u_air_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_air),
        .rd_addr (rd_addr),
        .rd_data (rd_air)
    );

    assign sts.count_zero = (count_reg == '0);
    assign sts.count_one  = (count_reg == CW'(1));
    assign sts.count_full = (count_reg == CW'(RING_DEPTH));
    assign sts.win_zero   = (window_reg == '0);
    assign sts.evict_hit  = (window_reg != '0) && (count_reg != '0) &&
                            (rd_end <= cutoff_reg);
    assign sts.rem_one    = (rem_reg == CW'(1));
    assign sts.out_free   = !m_valid_reg || m_tready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_RESET;
            oldest_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                window_reg <= cfg_data;
            end
            if (cmd.mrg_write) begin
                oldest_reg <= oldest_inc;
                count_reg  <= count_reg - 1'b1;
            end else if (cmd.append) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.evict) begin
                oldest_reg <= oldest_inc;
                count_reg  <= count_reg - 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            time_reg   <= in_time;
            air_reg    <= in_air;
            cutoff_reg <= cutoff_next;
        end
        if (cmd.cap_tmp) begin
            tmp_end_reg <= rd_end;
            tmp_air_reg <= rd_air;
        end
        if (cmd.clr_result) begin
            sum_reg <= '0;
            oe_reg  <= '0;
        end else if (cmd.peek) begin
            sum_reg <= '0;
            oe_reg  <= rd_end;
        end else if (cmd.sum_first) begin
            sum_reg <= rd_air;
            oe_reg  <= rd_end;
            ptr_reg <= oldest_inc;
            rem_reg <= count_reg - 1'b1;
        end else if (cmd.sum_acc) begin
            sum_reg <= sat_add(sum_reg, rd_air);
            ptr_reg <= ptr_inc;
            rem_reg <= rem_reg - 1'b1;
        end
        if (cmd.out_load) begin
            m_data_reg <= {oe_reg, sum_reg};
        end
    end

    assign window_length = window_reg;
    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = m_data_reg;

endmodule

`default_nettype wire

[sim/tb_awl_pkg.sv]
package tb_awl_pkg;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_QUERY  = 1'b1
    } ledger_op_t;

endpackage

[sim/awl_ledger_checker.sv]
module awl_ledger_checker
    import awl_pkg::*;
    import tb_awl_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // time_value, air_time
    input  logic                  s_tuser,   // opcode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,   // used_airtime, oldest_end
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [SUM_W-1:0]  used;
        logic [TIME_W-1:0] oldest;
    } usage_t;

    usage_t            usage_q[$];
    logic [TIME_W-1:0] window_len;
    logic [TIME_W-1:0] end_mem[RING_DEPTH];
    logic [SUM_W-1:0]  air_mem[RING_DEPTH];
    int                head;
    int                count;
    int                errs = 0;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] want,
                                   input logic [TIME_W-1:0] got);
        errs++;
        $display("mismatch %s: expected %0h got %0h", what, want, got);
    endtask

    task automatic ledger_apply(input ledger_op_t op, input logic [TIME_W-1:0] t_val,
                                input logic [AIR_W-1:0] air);
        int                nxt;
        int                slot;
        logic [TIME_W-1:0] cutoff;
        usage_t            u;
        u = '0;
        if (op == OP_RECORD) begin
            // full ring: fold the two oldest records into one
            if (count >= RING_DEPTH) begin
                nxt = (head + 1) % RING_DEPTH;
                if (end_mem[head] > end_mem[nxt]) begin
                    end_mem[nxt] = end_mem[head];
                end
                air_mem[nxt] = sat_sum(air_mem[head], air_mem[nxt]);
                head = nxt;
                count--;
            end
            slot = (head + count) % RING_DEPTH;
            end_mem[slot] = t_val;
            air_mem[slot] = SUM_W'(air);
            count++;
        end else begin
            if (window_len != '0) begin
                cutoff = (t_val > window_len) ? t_val - window_len : '0;
                while (count > 0 && end_mem[head] <= cutoff) begin
                    head = (head + 1) % RING_DEPTH;
                    count--;
                end
                for (int i = 0; i < count; i++) begin
                    u.used = sat_sum(u.used, air_mem[(head + i) % RING_DEPTH]);
                end
            end
            u.oldest = (count != 0) ? end_mem[head] : '0;
            usage_q.push_back(u);
        end
    endtask

    task automatic check_usage(input logic [SUM_W-1:0] used, input logic [TIME_W-1:0] oldest);
        usage_t u;
        if (usage_q.size() == 0) begin
            report_mismatch("result with no query", '0, used);
        end else begin
            u = usage_q.pop_front();
            if (used !== u.used) begin
                report_mismatch("used_airtime", u.used, used);
            end
            if (oldest !== u.oldest) begin
                report_mismatch("oldest_end", u.oldest, oldest);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            window_len = WINDOW_RESET;
            head       = 0;
            count      = 0;
            usage_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[3] == REG_WINDOW_LENGTH) begin
                window_len = pwdata[TIME_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                ledger_apply(ledger_op_t'(s_tuser), s_tdata[TIME_W-1:0],
                             s_tdata[TIME_W +: AIR_W]);
            end
            if (m_tvalid && m_tready) begin
                check_usage(m_tdata[SUM_W-1:0], m_tdata[SUM_W +: TIME_W]);
            end
        end
        pending    <= usage_q.size();
        fail_count <= errs;
    end

endmodule

[sim/tb_airtime_window_ledger.sv]
module tb_airtime_window_ledger;

    import awl_pkg::*;
    import tb_awl_pkg::*;

    localparam int RING_DEPTH = 16;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_LENGTH, 3'b000};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = {~REG_WINDOW_LENGTH, 3'b000};
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // time_value, air_time
    logic                  s_tuser = 1'b0; // opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // used_airtime, oldest_end
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                fail_count;
    int                pending;
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                hold_req = 0;
    int                hold_ack = 0;
    int                hold_left = 0;
    int                cycles = 0;
    logic [TIME_W-1:0] now_ms = '0;

    always #5 aclk = ~aclk;

    airtime_window_ledger #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    awl_ledger_checker #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ledger_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [AIR_W-1:0] rand_air();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return AIR_W'($urandom);
        endcase
    endfunction

    task automatic send_request(input ledger_op_t op, input logic [TIME_W-1:0] t_val,
                                input logic [AIR_W-1:0] air);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {air, t_val};
        do @(posedge aclk); while (!s_tready);
    endtask

    // let every query come back and any record still in flight settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (RING_DEPTH + 8) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [TIME_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word = {16'($urandom), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [TIME_W-1:0] window);
        wait_drain();
        apb_write(WINDOW_ADDR, window);
    endtask

    task automatic set_mode(input int sender_idle, input int recv_stall);
        idle_pct = sender_idle;
        stall_pct <= recv_stall;
    endtask

    // mostly a steady clock with real records and queries, some noise
    task automatic run_phase(input int n, input int unsigned step_max);
        ledger_op_t        op;
        logic [TIME_W-1:0] t_val;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 80) begin
                now_ms = now_ms + $urandom_range(step_max);
                op = ($urandom_range(99) < 55) ? OP_RECORD : OP_QUERY;
                t_val = now_ms;
            end else begin
                op = ledger_op_t'($urandom_range(1));
                t_val = rand_time();
            end
            send_request(op, t_val, rand_air());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty ring, zero cutoff, extremes, zero window, full ring
        send_request(OP_QUERY, '0, '0);
        send_request(OP_RECORD, '0, '0);
        send_request(OP_RECORD, 48'd5, '1);
        send_request(OP_QUERY, 48'd100, '1);
        send_request(OP_RECORD, TIME_MAX, '1);
        send_request(OP_QUERY, TIME_MAX, '0);
        configure('0);
        send_request(OP_QUERY, TIME_MAX, '0);
        for (int i = 0; i < RING_DEPTH + 1; i++) begin
            send_request(OP_RECORD, 48'(i * 3), i[0] ? 16'hFFFF : 16'(i));
        end
        send_request(OP_QUERY, '0, '0);
        configure(TIME_MAX);
        send_request(OP_QUERY, TIME_MAX, '0);
        send_request(OP_QUERY, 48'd40, '0);

        configure(48'd1000);
        set_mode(50, 0);
        now_ms = 48'd50_000;
        run_phase(200, 300);

        configure('0);
        set_mode(0, 50);
        run_phase(200, 1000);

        configure(TIME_MAX);
        set_mode(11, 11);
        run_phase(200, 1 << 20);

        configure(48'd1);
        set_mode(0, 0);
        run_phase(200, 2);

        // long receiver hold-off while the sender keeps pushing
        configure(rand_time());
        set_mode(0, 50);
        hold_req <= hold_req + 1;
        run_phase(80, 5000);
        wait_drain();
        run_phase(120, 5000);

        wait_drain();
        apb_write(SPARE_ADDR, rand_time());
        configure(48'd50_000);
        set_mode(50, 0);
        now_ms = rand_time();
        run_phase(200, 8000);

        configure(WINDOW_RESET);
        set_mode(11, 11);
        now_ms = '0;
        run_phase(200, 400_000);

        // keep folding full-scale airtime into the oldest record
        configure(TIME_MAX);
        set_mode(0, 0);
        for (int k = 1; k <= 32; k++) begin
            send_request(OP_RECORD, 48'(k), '1);
            if (k % 8 == 0) begin
                send_request(OP_QUERY, 48'(k), '0);
            end
        end
        send_request(OP_QUERY, 48'd70_000, '0);

        wait_drain();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/awl_pkg.sv
rtl/awl_ram.sv
rtl/awl_ctrl.sv
rtl/awl_dp.sv
rtl/airtime_window_ledger.sv
sim/tb_awl_pkg.sv
sim/awl_ledger_checker.sv
sim/tb_airtime_window_ledger.sv
